// ===== rtl/olrb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the overwriting log ring buffer.
// No dependencies; imported by every module of the block.
package olrb_pkg;

  localparam int unsigned DEPTH_DEF = 4096;
  localparam int unsigned FILL_W    = 13;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OP_W      = 2;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              read_valid;
    logic              overwrote_oldest;
    logic [FILL_W-1:0] fill_count;
  } out_beat_t;

  typedef struct packed {
    logic              read_valid;
    logic              overwrote_oldest;
    logic [FILL_W-1:0] fill_count;
  } ctrl_res_t;

endpackage

// ===== rtl/olrb_in_stage.sv =====
`timescale 1ns / 1ps
// Input register stage: captures one beat and hands it to the pointer control.
// Depends on olrb_pkg.
module olrb_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  olrb_pkg::in_beat_t in_data,
  input  logic              advance,
  output logic              proc,
  output olrb_pkg::in_beat_t beat
);
  import olrb_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_beat_t beat_r;
  logic     take;

  assign in_stall  = valid_r && !advance;
  assign take      = in_valid && !in_stall;
  assign proc      = valid_r && advance;
  assign beat      = beat_r;
  assign valid_nxt = take ? 1'b1 : (proc ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      beat_r <= in_data;
    end
  end

endmodule

// ===== rtl/olrb_ptr_ctrl.sv =====
`timescale 1ns / 1ps
// Head, tail and fill count of the ring; issues store accesses and result flags.
// Depends on olrb_pkg.
module olrb_ptr_ctrl #(
  parameter int unsigned DEPTH = olrb_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        proc,
  input  olrb_pkg::in_beat_t          beat,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [olrb_pkg::BYTE_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  output olrb_pkg::ctrl_res_t         res
);
  import olrb_pkg::*;

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rv;
  logic          ov;
  logic          full;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
    logic [AW-1:0] res_idx;
    if (idx == AW'(DEPTH - 1)) begin
      res_idx = '0;
    end else begin
      res_idx = idx + 1'b1;
    end
    return res_idx;
  endfunction

  assign full      = (count_r == CW'(DEPTH));
  assign mem_waddr = tail_r;
  assign mem_raddr = head_r;
  assign mem_wdata = beat.data_byte;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    rv        = 1'b0;
    ov        = 1'b0;
    case (beat.operation)
      OP_WRITE: begin
        mem_we   = proc;
        tail_nxt = wrap_inc(tail_r);
        if (!full) begin
          count_nxt = count_r + 1'b1;
        end else begin
          head_nxt = wrap_inc(tail_r);
          ov       = 1'b1;
        end
      end
      OP_READ: begin
        if (count_r != '0) begin
          mem_re    = proc;
          rv        = 1'b1;
          head_nxt  = wrap_inc(head_r);
          count_nxt = count_r - 1'b1;
        end
      end
      OP_CLEAR: begin
        head_nxt  = '0;
        tail_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign res.read_valid       = rv;
  assign res.overwrote_oldest = ov;
  assign res.fill_count       = FILL_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (proc) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0 && count_r != CW'(DEPTH)) |-> (head_r != tail_r))
    else $error("head meets tail while partly filled");

  a_full_write: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && beat.operation == OP_WRITE && full) |=>
      (count_r == CW'(DEPTH) && head_r == tail_r))
    else $error("overwrite lost full state");

  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && beat.operation == OP_READ && count_r == '0) |=>
      ($stable(head_r) && count_r == '0))
    else $error("read of empty ring moved state");

endmodule

// ===== rtl/olrb_store.sv =====
`timescale 1ns / 1ps
// Byte store of the ring: one write port, one read port with registered data.
// Depends on olrb_pkg.
module olrb_store #(
  parameter int unsigned DEPTH = olrb_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [olrb_pkg::BYTE_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [olrb_pkg::BYTE_W-1:0] rdata
);
  import olrb_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/overwriting_log_ring_buffer.sv =====
`timescale 1ns / 1ps
// Overwriting log ring buffer, top level. Depends on olrb_pkg and its submodules.
// Pipeline: the beat is captured in the input register, then its result in the
// result register; an output stall holds both registers.
// Throughput: one beat per cycle while the output is not stalled; input register,
// then pointer update and store access ahead of the result register.
// Reset: synchronous, active low; clears pointers, fill count and valids, not the store.
module overwriting_log_ring_buffer #(
  parameter int unsigned DEPTH = olrb_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  olrb_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output olrb_pkg::out_beat_t out_data
);
  import olrb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic              advance;
  logic              proc;
  in_beat_t          beat;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  ctrl_res_t         res;
  ctrl_res_t         res_r;
  logic              out_valid_r;
  logic              out_valid_nxt;

  assign advance       = !out_valid_r || !out_stall;
  assign out_valid_nxt = proc ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  olrb_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .proc     (proc),
    .beat     (beat)
  );

  olrb_ptr_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ptr_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc      (proc),
    .beat      (beat),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  olrb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res_r <= res;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_data.read_byte        = res_r.read_valid ? mem_rdata : '0;
    out_data.read_valid       = res_r.read_valid;
    out_data.overwrote_oldest = res_r.overwrote_oldest;
    out_data.fill_count       = res_r.fill_count;
  end

endmodule

// ===== tb/sv/tb_overwriting_log_ring_buffer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for overwriting_log_ring_buffer: directed, full-ring wrap
// and random beats, each result checked against a ring model kept in the bench.
// Depends on olrb_pkg and the RTL.
module tb_overwriting_log_ring_buffer;
  import olrb_pkg::*;

  localparam int unsigned RING_DEPTH = DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_BEATS = 800;
  localparam int unsigned OVERWRITES = 20;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;

  logic [BYTE_W-1:0] ring_bytes [RING_DEPTH];
  int unsigned oldest_idx;
  int unsigned write_idx;
  int unsigned bytes_held;
  out_beat_t pending_log_results[$];
  bit idling_on = 1'b1;
  int unsigned error_count;
  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned overwrites_seen;
  int unsigned bytes_returned;

  overwriting_log_ring_buffer #(
    .DEPTH(RING_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= idling_on && ($urandom_range(99) < 35);
  end

  function automatic int unsigned ring_next(input int unsigned idx);
    return (idx == RING_DEPTH - 1) ? 0 : idx + 1;
  endfunction

  function automatic out_beat_t ring_log_step(input in_beat_t beat);
    out_beat_t res;
    res = '0;
    case (beat.operation)
      OP_WRITE: begin
        ring_bytes[write_idx] = beat.data_byte;
        write_idx = ring_next(write_idx);
        if (bytes_held < RING_DEPTH) begin
          bytes_held++;
        end else begin
          oldest_idx = write_idx;
          res.overwrote_oldest = 1'b1;
        end
      end
      OP_READ: begin
        if (bytes_held != 0) begin
          res.read_byte = ring_bytes[oldest_idx];
          res.read_valid = 1'b1;
          oldest_idx = ring_next(oldest_idx);
          bytes_held--;
        end
      end
      OP_CLEAR: begin
        oldest_idx = 0;
        write_idx = 0;
        bytes_held = 0;
      end
      default: ;
    endcase
    res.fill_count = bytes_held[FILL_W-1:0];
    return res;
  endfunction

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data);
    in_beat_t beat;
    beat = '{operation: op, data_byte: data};
    while (idling_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_log_results.push_back(ring_log_step(beat));
    beats_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_log_results.size() != 0);
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_log_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("Unexpected result: byte=%02h valid=%0d overwrite=%0d fill=%0d",
                   out_data.read_byte, out_data.read_valid, out_data.overwrote_oldest,
                   out_data.fill_count);
      end else begin
        want = pending_log_results.pop_front();
        if (want.overwrote_oldest) overwrites_seen++;
        if (want.read_valid) bytes_returned++;
        if (out_data.read_byte !== want.read_byte || out_data.read_valid !== want.read_valid ||
            out_data.overwrote_oldest !== want.overwrote_oldest ||
            out_data.fill_count !== want.fill_count) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("Mismatch at result %0d: exp byte=%02h valid=%0d overwrite=%0d fill=%0d,",
                     results_seen, want.read_byte, want.read_valid, want.overwrote_oldest,
                     want.fill_count);
            $display("  got byte=%02h valid=%0d overwrite=%0d fill=%0d",
                     out_data.read_byte, out_data.read_valid,
                     out_data.overwrote_oldest, out_data.fill_count);
          end
        end
      end
    end
  end

  task automatic test_directed();
    send_beat(OP_READ, 8'hFF);
    send_beat(OP_UNUSED, 8'h81);
    send_beat(OP_WRITE, 8'h00);
    send_beat(OP_WRITE, 8'hFF);
    send_beat(OP_WRITE, 8'hA5);
    send_beat(OP_UNUSED, 8'h5A);
    send_beat(OP_READ, 8'h00);
    send_beat(OP_READ, 8'hFF);
    send_beat(OP_READ, 8'h3C);
    send_beat(OP_READ, 8'h55);
    send_beat(OP_WRITE, 8'h5A);
    send_beat(OP_WRITE, 8'h01);
    send_beat(OP_CLEAR, 8'hFF);
    send_beat(OP_READ, 8'h00);
    send_beat(OP_WRITE, 8'h80);
    send_beat(OP_READ, 8'h7F);
    send_beat(OP_CLEAR, 8'h00);
    send_beat(OP_CLEAR, 8'hAA);
  endtask

  task automatic test_full_ring_wrap();
    int unsigned i;
    // hold both sides busy through the fill
    idling_on <= 1'b0;
    send_beat(OP_CLEAR, BYTE_W'($urandom_range(255)));
    for (i = 0; i < RING_DEPTH + OVERWRITES; i++)
      send_beat(OP_WRITE, BYTE_W'($urandom_range(255)));
    idling_on <= 1'b1;
    // drain past the wrap of the oldest index and on into an empty ring
    for (i = 0; i < RING_DEPTH + 2; i++) send_beat(OP_READ, BYTE_W'($urandom_range(255)));
  endtask

  task automatic test_random_traffic();
    int unsigned i;
    int unsigned pick;
    logic [OP_W-1:0] op;
    for (i = 0; i < RANDOM_BEATS; i++) begin
      pick = $urandom_range(99);
      if (pick < 52) op = OP_WRITE;
      else if (pick < 91) op = OP_READ;
      else if (pick < 97) op = OP_UNUSED;
      else op = OP_CLEAR;
      send_beat(op, BYTE_W'($urandom_range(255)));
      if (i == RANDOM_BEATS / 2) drain_results();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_ring_wrap();
    test_random_traffic();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d beats: directed cases, a full-ring wrap with %0d overwrites, random mix.",
             beats_sent, OVERWRITES);
    $display("Checked %0d results, %0d flagged overwrites and %0d bytes read back.",
             results_seen, overwrites_seen, bytes_returned);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d errors found", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", pending_log_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/olrb_pkg.sv
rtl/olrb_in_stage.sv
rtl/olrb_ptr_ctrl.sv
rtl/olrb_store.sv
rtl/overwriting_log_ring_buffer.sv
tb/sv/tb_overwriting_log_ring_buffer.sv
